### hdl/velocity_profile_position_query_core_assert.svh
// assertion macros for the velocity profile position query core
// expects clk and rst in the scope where a macro is used
`ifndef VELOCITY_PROFILE_POSITION_QUERY_CORE_ASSERT_SVH
`define VELOCITY_PROFILE_POSITION_QUERY_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VPQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vpq check failed");

// antecedent implies consequent in the next cycle
`define VPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vpq check failed");

`endif

### hdl/vpq_pkg.sv
// shared types and constants of the velocity profile position query core
// no dependencies
`default_nettype none

package vpq_pkg;

  localparam int AXES     = 4;
  localparam int MAX_SEGS = 64;

  localparam int AXIS_IW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int SEG_IW  = $clog2(MAX_SEGS);
  localparam int CNT_W   = $clog2(MAX_SEGS + 1);
  localparam int DEPTH   = AXES * MAX_SEGS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = PROD_W + $clog2(MAX_SEGS) + 2;
  localparam int NUM_W   = 65;
  localparam int DCNT_W  = $clog2(NUM_W + 1);

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_AXIS = 3'd1;
  localparam logic [2:0] ST_PAST_END = 3'd2;
  localparam logic [2:0] ST_NO_SEG   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         axis;
    logic [31:0]        start_time;
    logic signed [31:0] start_velocity;
    logic [31:0]        end_time;
    logic signed [31:0] end_velocity;
    logic [31:0]        query_time;
  } req_t;

  typedef struct packed {
    logic signed [63:0] position;
    logic signed [31:0] velocity;
    logic [2:0]         status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start_time;
    logic [31:0] start_velocity;
    logic [31:0] end_time;
    logic [31:0] end_velocity;
  } seg_t;

endpackage

`default_nettype wire

### hdl/velocity_profile_position_query_core.sv
// velocity profile position query core: segment store, scan sequencer and
// one shared multiplier with a bit-serial divider; uses vpq_pkg and the
// assertion macro header
`default_nettype none

// usage
//   req channel (req_valid / req_stall / req) carries one request word:
//   clear all axes, append a segment to an axis, or query an axis at a time.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one word per request.
//   one request is in flight at a time: req_stall is high from acceptance
//   until the response word has been taken.
// steps
//   clear, append and bad requests: straight to the response word
//   query: check the motion end, then one segment per cycle
//   scanned before the containing one (single read port of the segment
//   memory, one shared 34x34 multiplier), then S_MUL1, 65 divider steps
//   (skipped for a zero-length segment), then S_MUL2, S_ACC and S_FIN;
//   next request in the cycle after the response word is taken
// reset
//   rst clears all segment counts and returns to idle; the segment memory
//   holds stale data, which is never used beyond the counts
// stall
//   while rsp_stall is high a shown response word holds and no request is taken
module velocity_profile_position_query_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire vpq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output vpq_pkg::rsp_t      rsp
);

`include "velocity_profile_position_query_core_assert.svh"

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MEND = 9'b000000010,
    S_SCAN = 9'b000000100,
    S_MUL1 = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_MUL2 = 9'b000100000,
    S_ACC  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;

  // segment store and per-axis fill counts
  vpq_pkg::seg_t mem [vpq_pkg::DEPTH];
  vpq_pkg::seg_t rdata;
  logic [vpq_pkg::ADDR_W-1:0] rd_addr;
  logic [vpq_pkg::ADDR_W-1:0] wr_addr;
  logic                       wr_en;
  logic [vpq_pkg::CNT_W-1:0]  counts [vpq_pkg::AXES];

  // query context
  logic [vpq_pkg::AXIS_IW-1:0] axis_q;
  logic [31:0]                 qt;
  logic [vpq_pkg::CNT_W-1:0]   seg_n;
  logic [vpq_pkg::CNT_W-1:0]   scan_idx;
  logic [vpq_pkg::ADDR_W-1:0]  base;
  logic [vpq_pkg::ADDR_W-1:0]  req_base;

  // arithmetic
  logic signed [vpq_pkg::MUL_W-1:0]  mul_a;
  logic signed [vpq_pkg::MUL_W-1:0]  mul_b;
  logic signed [vpq_pkg::PROD_W-1:0] mul_p;
  logic signed [vpq_pkg::PROD_W-1:0] prod;
  logic                              prod_pend;
  logic signed [vpq_pkg::ACC_W-1:0]  acc;
  logic signed [vpq_pkg::ACC_W-1:0]  acc_sum;
  logic signed [vpq_pkg::ACC_W-1:0]  acc_sh;
  logic signed [31:0]                v0;
  logic signed [31:0]                v1;
  logic signed [31:0]                vq;
  logic [31:0]                       d;
  logic [31:0]                       dd;
  logic signed [vpq_pkg::MUL_W-1:0]  diff;
  logic [32:0]                       md;
  logic signed [vpq_pkg::MUL_W-1:0]  vq_wide;

  // divider
  logic [vpq_pkg::NUM_W-1:0]  num;
  logic [31:0]                rem;
  logic [32:0]                rem_sh;
  logic [32:0]                rem_sub;
  logic                       rem_ge;
  logic [vpq_pkg::DCNT_W-1:0] div_cnt;

  logic        req_ok;
  logic        axis_bad;
  logic [31:0] mend;
  logic        hit;
  logic        top_same;

  assign req_stall = (state != S_IDLE);
  assign req_ok    = req_valid && !req_stall;
  assign rsp_valid = (state == S_DONE);
  assign axis_bad  = ({1'b0, req.axis} >= 4'(vpq_pkg::AXES));

  assign req_base = vpq_pkg::ADDR_W'(req.axis[vpq_pkg::AXIS_IW-1:0]) *
                    vpq_pkg::ADDR_W'(vpq_pkg::MAX_SEGS);
  assign base     = vpq_pkg::ADDR_W'(axis_q) * vpq_pkg::ADDR_W'(vpq_pkg::MAX_SEGS);

  assign wr_addr = req_base +
                   vpq_pkg::ADDR_W'(counts[req.axis[vpq_pkg::AXIS_IW-1:0]]);
  assign wr_en   = req_ok && (req.req_type == vpq_pkg::REQ_APPEND) && !axis_bad &&
                   (counts[req.axis[vpq_pkg::AXIS_IW-1:0]] !=
                    vpq_pkg::CNT_W'(vpq_pkg::MAX_SEGS));

  // read address: motion end of axis 0, then segments in order
  always_comb begin
    case (state)
      S_IDLE:  rd_addr = vpq_pkg::ADDR_W'(counts[0] - vpq_pkg::CNT_W'(1));
      S_MEND:  rd_addr = base;
      S_SCAN:  rd_addr = base + vpq_pkg::ADDR_W'(scan_idx[vpq_pkg::SEG_IW-1:0] +
                                                 vpq_pkg::SEG_IW'(1));
      default: rd_addr = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{start_time: req.start_time, start_velocity: req.start_velocity,
                        end_time: req.end_time, end_velocity: req.end_velocity};
    end
    rdata <= mem[rd_addr];
  end

  // interpolation terms
  assign diff    = vpq_pkg::MUL_W'(v1) - vpq_pkg::MUL_W'(v0);
  assign md      = diff[vpq_pkg::MUL_W-1] ? 33'(-diff) : 33'(diff);
  assign vq_wide = diff[vpq_pkg::MUL_W-1] ?
                   vpq_pkg::MUL_W'(v0) - $signed({1'b0, num[32:0]}) :
                   vpq_pkg::MUL_W'(v0) + $signed({1'b0, num[32:0]});

  // shared multiplier
  always_comb begin
    case (state)
      S_SCAN: begin
        mul_a = vpq_pkg::MUL_W'($signed(rdata.start_velocity)) +
                vpq_pkg::MUL_W'($signed(rdata.end_velocity));
        mul_b = $signed({2'b00, rdata.end_time}) - $signed({2'b00, rdata.start_time});
      end
      S_MUL1: begin
        mul_a = $signed({1'b0, md});
        mul_b = $signed({2'b00, d});
      end
      S_MUL2: begin
        mul_a = vpq_pkg::MUL_W'(v0) + vpq_pkg::MUL_W'($signed(vq_wide[31:0]));
        mul_b = $signed({2'b00, d});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign acc_sum = acc + vpq_pkg::ACC_W'(prod);

  // restoring divider step
  assign rem_sh  = {rem, num[vpq_pkg::NUM_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dd});
  assign rem_sub = rem_sh - {1'b0, dd};

  assign mend = (counts[0] == '0) ? 32'd0 : rdata.end_time;
  assign hit  = (rdata.start_time <= qt) && (qt <= rdata.end_time);

  // halve with floor, then saturate to 64 bits
  assign acc_sh   = acc >>> 1;
  assign top_same = (&acc_sh[vpq_pkg::ACC_W-1:63]) || !(|acc_sh[vpq_pkg::ACC_W-1:63]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < vpq_pkg::AXES; i++) begin
        counts[i] <= '0;
      end
      prod_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_ok) begin
            rsp.position <= '0;
            rsp.velocity <= '0;
            axis_q <= req.axis[vpq_pkg::AXIS_IW-1:0];
            qt     <= req.query_time;
            seg_n  <= counts[req.axis[vpq_pkg::AXIS_IW-1:0]];
            case (req.req_type)
              vpq_pkg::REQ_CLEAR: begin
                rsp.status <= vpq_pkg::ST_OK;
                state      <= S_DONE;
                for (int i = 0; i < vpq_pkg::AXES; i++) begin
                  counts[i] <= '0;
                end
              end
              vpq_pkg::REQ_APPEND: begin
                state <= S_DONE;
                if (axis_bad) begin
                  rsp.status <= vpq_pkg::ST_BAD_AXIS;
                end else if (!wr_en) begin
                  rsp.status <= vpq_pkg::ST_FULL;
                end else begin
                  rsp.status <= vpq_pkg::ST_OK;
                  counts[req.axis[vpq_pkg::AXIS_IW-1:0]] <=
                    counts[req.axis[vpq_pkg::AXIS_IW-1:0]] + vpq_pkg::CNT_W'(1);
                end
              end
              vpq_pkg::REQ_QUERY: begin
                if (axis_bad) begin
                  rsp.status <= vpq_pkg::ST_BAD_AXIS;
                  state      <= S_DONE;
                end else begin
                  rsp.status <= vpq_pkg::ST_OK;
                  state      <= S_MEND;
                end
              end
              default: begin
                rsp.status <= vpq_pkg::ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_MEND: begin
          scan_idx  <= '0;
          acc       <= '0;
          prod_pend <= 1'b0;
          if (qt > mend) begin
            rsp.status <= vpq_pkg::ST_PAST_END;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (prod_pend) begin
            acc <= acc_sum;
          end
          if (scan_idx == seg_n) begin
            rsp.status <= vpq_pkg::ST_NO_SEG;
            state      <= S_DONE;
          end else if (hit) begin
            prod_pend <= 1'b0;
            v0 <= $signed(rdata.start_velocity);
            v1 <= $signed(rdata.end_velocity);
            d  <= qt - rdata.start_time;
            dd <= rdata.end_time - rdata.start_time;
            // zero-length segment: quotient zero, velocity is the start value
            if (rdata.end_time == rdata.start_time) begin
              num   <= '0;
              state <= S_MUL2;
            end else begin
              state <= S_MUL1;
            end
          end else begin
            prod      <= mul_p;
            prod_pend <= 1'b1;
            scan_idx  <= scan_idx + vpq_pkg::CNT_W'(1);
          end
        end
        S_MUL1: begin
          num     <= mul_p[vpq_pkg::NUM_W-1:0];
          rem     <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
          num     <= {num[vpq_pkg::NUM_W-2:0], rem_ge};
          div_cnt <= div_cnt + vpq_pkg::DCNT_W'(1);
          if (div_cnt == vpq_pkg::DCNT_W'(vpq_pkg::NUM_W - 1)) begin
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          prod  <= mul_p;
          vq    <= vq_wide[31:0];
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= acc_sum;
          state <= S_FIN;
        end
        S_FIN: begin
          rsp.velocity <= vq;
          rsp.status   <= vpq_pkg::ST_OK;
          if (top_same) begin
            rsp.position <= acc_sh[63:0];
          end else if (acc_sh[vpq_pkg::ACC_W-1]) begin
            rsp.position <= {1'b1, 63'd0};
          end else begin
            rsp.position <= {1'b0, {63{1'b1}}};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no request is taken while a response word waits
  `VPQ_ASSERT_IMPL(a_busy_while_rsp, rsp_valid, req_stall)
  // a taken response word is not shown again
  `VPQ_ASSERT_NEXT(a_rsp_once, rsp_valid && !rsp_stall, !rsp_valid)
  // the scan never runs past the axis count
  `VPQ_ASSERT_IMPL(a_scan_bound, state == S_SCAN, scan_idx <= seg_n)
  // axis 0 never holds more than the store depth per axis
  `VPQ_ASSERT_IMPL(a_count_bound, 1'b1, counts[0] <= vpq_pkg::CNT_W'(vpq_pkg::MAX_SEGS))

endmodule

`default_nettype wire

### tb/tb.sv
// testbench for the velocity profile position query core: builds random
// segment profiles, queries them and checks every response word
// depends on vpq_pkg and velocity_profile_position_query_core
`timescale 1ns / 1ps
`default_nettype none

module tb;

  // request code with no effect on the core
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int TOTAL_WORDS = 1850;
  localparam int QUIET_AFTER = 1550;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 200;

  // tracks the segment store and predicts the response word of each request
  class profile_tracker;
    logic [31:0] seg_t0 [vpq_pkg::AXES][vpq_pkg::MAX_SEGS];
    logic [31:0] seg_t1 [vpq_pkg::AXES][vpq_pkg::MAX_SEGS];
    logic signed [31:0] seg_v0 [vpq_pkg::AXES][vpq_pkg::MAX_SEGS];
    logic signed [31:0] seg_v1 [vpq_pkg::AXES][vpq_pkg::MAX_SEGS];
    int unsigned seg_count [vpq_pkg::AXES];
    vpq_pkg::rsp_t pending_answers [$];
    int errors;

    function new();
      errors = 0;
      foreach (seg_count[i]) seg_count[i] = 0;
    endfunction

    // position and velocity of axis ax at time qt; axis and motion end already checked
    function vpq_pkg::rsp_t evaluate(int unsigned ax, logic [31:0] qt);
      vpq_pkg::rsp_t a;
      logic signed [127:0] acc, s, dt, v0, v1, vq, d, dd, diff, q, pos;
      int unsigned hit, n;
      a = '0;
      n = seg_count[ax];
      hit = n;
      for (int i = n - 1; i >= 0; i--)
        if (seg_t0[ax][i] <= qt && qt <= seg_t1[ax][i]) hit = i;
      if (hit == n) begin
        a.status = vpq_pkg::ST_NO_SEG;
        return a;
      end
      acc = '0;
      for (int i = 0; i < hit; i++) begin
        v0 = seg_v0[ax][i];
        v1 = seg_v1[ax][i];
        s = v0 + v1;
        dt = seg_t1[ax][i];
        dt = dt - seg_t0[ax][i];
        acc = acc + s * dt;
      end
      v0 = seg_v0[ax][hit];
      v1 = seg_v1[ax][hit];
      d = qt;
      d = d - seg_t0[ax][hit];
      dd = seg_t1[ax][hit];
      dd = dd - seg_t0[ax][hit];
      vq = v0;
      if (dd > 0) begin
        diff = v1 - v0;
        q = ((diff < 0) ? -diff : diff) * d / dd;
        vq = (diff < 0) ? v0 - q : v0 + q;
      end
      acc = acc + (v0 + vq) * d;
      pos = acc >>> 1;
      // saturate to the 64-bit signed range
      if (pos > $signed({64'b0, 1'b0, {63{1'b1}}}))
        a.position = {1'b0, {63{1'b1}}};
      else if (pos < $signed({{64{1'b1}}, 1'b1, 63'b0}))
        a.position = {1'b1, 63'b0};
      else
        a.position = pos[63:0];
      a.velocity = vq[31:0];
      a.status = vpq_pkg::ST_OK;
      return a;
    endfunction

    function void note_request(vpq_pkg::req_t r);
      vpq_pkg::rsp_t a;
      int unsigned n0;
      logic [31:0] motion_end;
      a = '0;
      case (r.req_type)
        vpq_pkg::REQ_CLEAR: begin
          foreach (seg_count[i]) seg_count[i] = 0;
        end
        vpq_pkg::REQ_APPEND: begin
          if (r.axis >= vpq_pkg::AXES) a.status = vpq_pkg::ST_BAD_AXIS;
          else if (seg_count[r.axis] >= vpq_pkg::MAX_SEGS) a.status = vpq_pkg::ST_FULL;
          else begin
            seg_t0[r.axis][seg_count[r.axis]] = r.start_time;
            seg_v0[r.axis][seg_count[r.axis]] = r.start_velocity;
            seg_t1[r.axis][seg_count[r.axis]] = r.end_time;
            seg_v1[r.axis][seg_count[r.axis]] = r.end_velocity;
            seg_count[r.axis]++;
          end
        end
        vpq_pkg::REQ_QUERY: begin
          n0 = seg_count[0];
          motion_end = (n0 != 0) ? seg_t1[0][n0 - 1] : 32'd0;
          if (r.axis >= vpq_pkg::AXES) a.status = vpq_pkg::ST_BAD_AXIS;
          else if (r.query_time > motion_end) a.status = vpq_pkg::ST_PAST_END;
          else a = evaluate(r.axis, r.query_time);
        end
        default: ;
      endcase
      pending_answers = {pending_answers, a};
    endfunction

    function void check_answer(vpq_pkg::rsp_t got);
      vpq_pkg::rsp_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected response word, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.position !== want.position) begin
        $display("%0t: position mismatch, expected %h actual %h", $time,
                 want.position, got.position);
        errors++;
      end
      if (got.velocity !== want.velocity) begin
        $display("%0t: velocity mismatch, expected %h actual %h", $time,
                 want.velocity, got.velocity);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time,
                 want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  vpq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  vpq_pkg::rsp_t rsp;

  profile_tracker tracker = new();
  int words_sent = 0;
  bit quiet = 1'b0;
  int cycles = 0;
  vpq_pkg::seg_t profile [vpq_pkg::AXES][$];

  velocity_profile_position_query_core dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** velocity_profile_position_query_core: FAILED **");
      $finish;
    end
  end

  // response side: check every accepted word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) tracker.check_answer(rsp);
  end

  // response stall in random bursts, none in the quiet tail
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_stall = 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
      rsp_stall = 1'b0;
    end
  end

  function automatic vpq_pkg::req_t make_word(logic [1:0] rt, int unsigned ax,
                                              logic [31:0] t0, logic [31:0] v0,
                                              logic [31:0] t1, logic [31:0] v1,
                                              logic [31:0] qt);
    vpq_pkg::req_t r;
    r.req_type = rt;
    r.axis = 3'(ax);
    r.start_time = t0;
    r.start_velocity = v0;
    r.end_time = t1;
    r.end_velocity = v1;
    r.query_time = qt;
    return r;
  endfunction

  // drive one request word; called and returns at a falling edge
  task automatic send_word(vpq_pkg::req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req = r;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    tracker.note_request(r);
    words_sent++;
    if (words_sent > QUIET_AFTER) quiet = 1'b1;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_velocity();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  function automatic logic [31:0] clip(longint unsigned t);
    return (t > 64'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
  endfunction

  // one profile set: clear, interleaved appends, then queries into it
  task automatic run_profile_set();
    longint unsigned cursor, max_end, span, t0, t1;
    int unsigned n, ax, nq, k;
    vpq_pkg::seg_t sg;
    logic [31:0] qt, tmp;
    vpq_pkg::req_t r;
    case ($urandom_range(0, 3))
      0: span = 20;
      1: span = 5000;
      2: span = 1 << 24;
      default: span = 64'h80000000;
    endcase
    send_word(make_word(vpq_pkg::REQ_CLEAR, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
    max_end = 0;
    for (int a = 0; a < vpq_pkg::AXES; a++) begin
      profile[a].delete();
      n = ($urandom_range(0, 14) == 0) ? vpq_pkg::MAX_SEGS + 2 : $urandom_range(1, 5);
      cursor = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 2) != 0) cursor = cursor + $urandom_range(0, span);
        t0 = cursor;
        t1 = ($urandom_range(0, 7) == 0) ? t0 : t0 + $urandom_range(1, span);
        cursor = t1;
        sg.start_time = clip(t0);
        sg.end_time = clip(t1);
        if ($urandom_range(0, 19) == 0) begin
          tmp = sg.start_time;
          sg.start_time = sg.end_time;
          sg.end_time = tmp;
        end
        sg.start_velocity = pick_velocity();
        sg.end_velocity = pick_velocity();
        profile[a] = {profile[a], sg};
        if (clip(t1) > max_end) max_end = clip(t1);
      end
    end
    // axis 0 ends last so that other axes stay inside the motion
    sg.start_time = profile[0][$].end_time;
    sg.end_time = clip(max_end + $urandom_range(0, 3));
    if (sg.start_time > sg.end_time) sg.start_time = sg.end_time;
    sg.start_velocity = pick_velocity();
    sg.end_velocity = pick_velocity();
    profile[0] = {profile[0], sg};

    // appends interleaved across axes, order kept within each axis
    begin
      int unsigned idx [vpq_pkg::AXES];
      int unsigned left;
      foreach (idx[i]) idx[i] = 0;
      left = 0;
      for (int a = 0; a < vpq_pkg::AXES; a++) left += profile[a].size();
      while (left > 0) begin
        ax = $urandom_range(0, vpq_pkg::AXES - 1);
        if (idx[ax] < profile[ax].size()) begin
          sg = profile[ax][idx[ax]];
          send_word(make_word(vpq_pkg::REQ_APPEND, ax, sg.start_time, sg.start_velocity,
                              sg.end_time, sg.end_velocity, $urandom));
          idx[ax]++;
          left--;
        end
        if ($urandom_range(0, 24) == 0) begin
          // noise: unused code or request on a bad axis
          r = make_word($urandom_range(0, 1) ? REQ_NONE : vpq_pkg::REQ_APPEND,
                        $urandom_range(vpq_pkg::AXES, 7), $urandom, $urandom, $urandom,
                        $urandom, $urandom);
          send_word(r);
        end
      end
    end

    nq = $urandom_range(4, 14);
    for (int i = 0; i < nq; i++) begin
      ax = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) :
           $urandom_range(0, vpq_pkg::AXES - 1);
      if (ax >= vpq_pkg::AXES) begin
        qt = $urandom;
      end else begin
        k = $urandom_range(0, profile[ax].size() - 1);
        sg = profile[ax][k];
        case ($urandom_range(0, 6))
          0: qt = sg.start_time;
          1: qt = sg.end_time;
          2: qt = $urandom;
          3: qt = clip(longint'(profile[0][$].end_time) + 1);
          default: begin
            if (sg.end_time >= sg.start_time)
              qt = 32'(sg.start_time + (longint'($urandom) % (longint'(sg.end_time)
                   - sg.start_time + 1)));
            else
              qt = $urandom_range(sg.end_time, sg.start_time);
          end
        endcase
      end
      send_word(make_word(vpq_pkg::REQ_QUERY, ax, $urandom, $urandom, $urandom,
                          $urandom, qt));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty store, zero-length and full-range segments, reversed
    // segment, bad axes, unused code, clear
    send_word(make_word(vpq_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 32'd0));
    send_word(make_word(vpq_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 32'd1));
    send_word(make_word(vpq_pkg::REQ_APPEND, 0, 32'd0, 32'h7FFFFFFF, 32'd0,
                        32'h80000000, 0));
    send_word(make_word(vpq_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 32'd0));
    send_word(make_word(vpq_pkg::REQ_APPEND, 0, 32'd10, 32'h80000000, 32'hFFFFFFFF,
                        32'h7FFFFFFF, 0));
    send_word(make_word(vpq_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 32'd5));
    send_word(make_word(vpq_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 32'd10));
    send_word(make_word(vpq_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 32'h80000000));
    send_word(make_word(vpq_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 32'hFFFFFFFF));
    send_word(make_word(vpq_pkg::REQ_APPEND, 1, 32'd100, 32'h7FFFFFFF, 32'd50,
                        32'h7FFFFFFF, 0));
    send_word(make_word(vpq_pkg::REQ_QUERY, 1, 0, 0, 0, 0, 32'd75));
    send_word(make_word(vpq_pkg::REQ_APPEND, 1, 32'd0, 32'h7FFFFFFF, 32'hFFFFFFFF,
                        32'h7FFFFFFF, 0));
    send_word(make_word(vpq_pkg::REQ_QUERY, 1, 0, 0, 0, 0, 32'hFFFFFFFF));
    send_word(make_word(vpq_pkg::REQ_APPEND, 7, 0, 0, 5, 0, 0));
    send_word(make_word(vpq_pkg::REQ_APPEND, 4, 0, 0, 5, 0, 0));
    send_word(make_word(vpq_pkg::REQ_QUERY, 6, 0, 0, 0, 0, 32'd0));
    send_word(make_word(REQ_NONE, 7, '1, '1, '1, '1, '1));
    send_word(make_word(vpq_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    send_word(make_word(vpq_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 32'd0));

    while (words_sent < TOTAL_WORDS) run_profile_set();

    req_valid = 1'b0;
    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("** velocity_profile_position_query_core: PASSED **");
    else
      $display("** velocity_profile_position_query_core: FAILED **");
    $finish;
  end
endmodule

`default_nettype wire
